// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dpp_pkg.sv -----
package dpp_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        KIND_CMD    = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_ACCEPT = 3'd2,
        KIND_REJECT = 3'd3,
        KIND_INTR   = 3'd4
    } kind_t;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_BODY    = 8'b0000_0010,
        PH_ESCAPE  = 8'b0000_0100,
        PH_CHK_HI  = 8'b0000_1000,
        PH_CHK_LO  = 8'b0001_0000,
        PH_SKIP    = 8'b0010_0000,
        PH_SKIP_HI = 8'b0100_0000,
        PH_SKIP_LO = 8'b1000_0000
    } phase_t;

    localparam byte_t CH_DOLLAR = 8'h24;
    localparam byte_t CH_HASH   = 8'h23;
    localparam byte_t CH_PLUS   = 8'h2B;
    localparam byte_t CH_INTR   = 8'h03;
    localparam byte_t CH_ESC    = 8'h7D;
    localparam byte_t CH_NUL    = 8'h00;
    localparam byte_t ESC_XOR   = 8'h20;
    localparam byte_t CH_COLON  = 8'h3A;
    localparam byte_t CH_DOT    = 8'h2E;
    localparam byte_t CH_SEMI   = 8'h3B;
    localparam byte_t CH_Q      = 8'h71;
    localparam byte_t CH_V      = 8'h76;

    localparam logic [1:0] ACK_MAX = 2'd2;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] ack_count;
        logic       in_command;
        logic       cmd_len_nz;
        byte_t      running_sum;
        logic [3:0] high_nibble;
    } state_t;

    typedef struct packed {
        logic  emit;
        kind_t kind;
        byte_t value;
    } result_t;

    // Hex digit value; anything that is not a hex digit reads as zero.
    function automatic logic [3:0] hex_digit(input byte_t b);
        logic [3:0] d;
        d = 4'd0;
        if (b inside {[8'h30:8'h39]})
            d = b[3:0];
        else if (b inside {[8'h61:8'h66], [8'h41:8'h46]})
            d = b[3:0] + 4'd9;
        return d;
    endfunction

endpackage

// ----- rtl/dpp_step.sv -----
module dpp_step (
    input  dpp_pkg::state_t  state,
    input  dpp_pkg::byte_t   rx,
    output dpp_pkg::state_t  state_next,
    output dpp_pkg::result_t res
);
    import dpp_pkg::*;

    byte_t dec;
    logic  cmd_after_split;
    logic  cls_in_command;
    logic  cls_len_nz;
    kind_t cls_kind;
    byte_t got;

    // Escape decoding, command/data tagging of the decoded byte, and the received checksum.
    always_comb
    begin
        dec             = (state.phase == PH_ESCAPE) ? (rx ^ ESC_XOR) : rx;
        cmd_after_split = state.in_command && !(dec inside {CH_COLON, CH_DOT, CH_SEMI});
        cls_in_command  = cmd_after_split;
        cls_len_nz      = state.cmd_len_nz;
        cls_kind        = KIND_DATA;
        if (cmd_after_split)
        begin
            cls_kind = KIND_CMD;
            if (!state.cmd_len_nz)
            begin
                cls_len_nz = 1'b1;
                if (!(dec inside {CH_Q, CH_V}))
                    cls_in_command = 1'b0;
            end
        end
        got = {state.high_nibble, hex_digit(rx)};
    end

    always_comb
    begin
        state_next = state;
        res.emit   = 1'b0;
        res.kind   = KIND_DATA;
        res.value  = dec;
        case (state.phase)
            PH_IDLE:
            begin
                if (rx == CH_DOLLAR)
                begin
                    state_next.phase       = PH_BODY;
                    state_next.in_command  = 1'b1;
                    state_next.cmd_len_nz  = 1'b0;
                    state_next.running_sum = '0;
                end
                else if (rx == CH_PLUS && state.ack_count < ACK_MAX)
                    state_next.ack_count = state.ack_count + 2'd1;
                else if (rx == CH_INTR)
                begin
                    state_next.ack_count = '0;
                    res.emit  = 1'b1;
                    res.kind  = KIND_INTR;
                    res.value = '0;
                end
                else
                    state_next.phase = (rx == CH_HASH) ? PH_SKIP_HI : PH_SKIP;
            end
            PH_BODY:
            begin
                if (rx == CH_HASH || rx == CH_NUL)
                    state_next.phase = PH_CHK_HI;
                else
                begin
                    state_next.running_sum = state.running_sum + rx;
                    if (rx == CH_ESC)
                        state_next.phase = PH_ESCAPE;
                    else
                    begin
                        state_next.in_command = cls_in_command;
                        state_next.cmd_len_nz = cls_len_nz;
                        res.emit = 1'b1;
                        res.kind = cls_kind;
                    end
                end
            end
            PH_ESCAPE:
            begin
                state_next.running_sum = state.running_sum + rx;
                state_next.phase       = PH_BODY;
                state_next.in_command  = cls_in_command;
                state_next.cmd_len_nz  = cls_len_nz;
                res.emit = 1'b1;
                res.kind = cls_kind;
            end
            PH_CHK_HI:
            begin
                state_next.high_nibble = hex_digit(rx);
                state_next.phase       = PH_CHK_LO;
            end
            PH_CHK_LO:
            begin
                state_next.phase     = PH_IDLE;
                state_next.ack_count = '0;
                res.emit  = 1'b1;
                res.kind  = (got == state.running_sum) ? KIND_ACCEPT : KIND_REJECT;
                res.value = state.running_sum;
            end
            PH_SKIP:
            begin
                if (rx == CH_HASH)
                    state_next.phase = PH_SKIP_HI;
            end
            PH_SKIP_HI:
                state_next.phase = PH_SKIP_LO;
            PH_SKIP_LO:
            begin
                state_next.phase     = PH_IDLE;
                state_next.ack_count = '0;
                res.emit  = 1'b1;
                res.kind  = KIND_REJECT;
                res.value = '0;
            end
            default:
            begin
                state_next.phase     = PH_IDLE;
                state_next.ack_count = '0;
            end
        endcase
    end

endmodule

// ----- rtl/debug_packet_parser_core.sv -----
// Channel   Direction  Handshake            Word
// rx        in         rx_valid / rx_stall  rx_byte  (one raw link byte)
// res       out        res_valid / res_stall kind, value (tagged byte, verdict or interrupt)
//
// One byte a cycle, back to back, while rx_stall stays low.
// The byte waits in an input register; the parse step runs between it and the result register.
// rx_stall rises only while a byte is held and the result register is full and stalled.
// Bytes that yield no result still pass through the step and free the input register.
// rst_n (asynchronous, active low) returns the parser to idle with both registers empty.
module debug_packet_parser_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rx_valid,
    output logic            rx_stall,
    input  dpp_pkg::byte_t  rx_byte,
    output logic            res_valid,
    input  logic            res_stall,
    output dpp_pkg::kind_t  kind,
    output dpp_pkg::byte_t  value
);
    import dpp_pkg::*;

    `include "assert_macros.svh"

    localparam state_t STATE_RESET = '{
        phase:       PH_IDLE,
        ack_count:   2'd0,
        in_command:  1'b1,
        cmd_len_nz:  1'b0,
        running_sum: 8'd0,
        high_nibble: 4'd0
    };

    logic    in_valid_reg;
    logic    in_valid_next;
    byte_t   in_byte_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    logic    out_valid_reg;
    logic    out_valid_next;
    kind_t   out_kind_reg;
    byte_t   out_value_reg;
    logic    advance;
    logic    verdict_taken;
    logic    parser_at_rest;

    // Advance the held byte whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || !res_stall);
    assign rx_stall = in_valid_reg && !advance;

    dpp_step u_step (
        .state      (state_reg),
        .rx         (in_byte_reg),
        .state_next (state_next),
        .res        (step_res)
    );

    always_comb
    begin
        // Hold the byte while stalled, otherwise take whatever arrives.
        in_valid_next = rx_stall ? 1'b1 : rx_valid;
        if (advance)
            out_valid_next = step_res.emit;
        else if (!res_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (!rx_stall && rx_valid)
            in_byte_reg <= rx_byte;
        if (advance && step_res.emit)
        begin
            out_kind_reg  <= step_res.kind;
            out_value_reg <= step_res.value;
        end
    end

    assign res_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign value     = out_value_reg;

    // A verdict or an interrupt leaves the parser idle with the '+' count cleared.
    assign verdict_taken  = advance && step_res.emit &&
                            !(step_res.kind inside {KIND_CMD, KIND_DATA});
    assign parser_at_rest = (state_reg.phase == PH_IDLE) && (state_reg.ack_count == 2'd0);

    `ASSERT_NEXT(a_held_byte_kept, rx_stall, in_valid_reg, "held byte dropped")
    `ASSERT_ALWAYS(a_ack_bound, state_reg.ack_count != 2'd3, "plus count overran")
    `ASSERT_NEXT(a_verdict_idle, verdict_taken, parser_at_rest, "parser not idle after verdict")
    `ASSERT_NEXT(a_emit_loaded, advance && step_res.emit, res_valid, "result lost")

endmodule
